/* rtl/wse_pkg.sv */
`timescale 1ns / 1ps
package wse_pkg;

  localparam int LenW   = 63;
  localparam int KeyW   = 32;
  localparam int ByteW  = 8;
  localparam int CmdW   = 3;
  localparam int IdxW   = 4;   // byte index inside one frame piece, up to 14 bytes
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;

  // Command codes
  localparam logic [CmdW-1:0] CMD_START = 3'd0;
  localparam logic [CmdW-1:0] CMD_DATA  = 3'd1;
  localparam logic [CmdW-1:0] CMD_CLOSE = 3'd2;
  localparam logic [CmdW-1:0] CMD_PING  = 3'd3;
  localparam logic [CmdW-1:0] CMD_PONG  = 3'd4;

  // Frame header constants
  localparam logic [ByteW-1:0] HDR_TEXT   = 8'h81;  // FIN + text opcode
  localparam logic [ByteW-1:0] HDR_CLOSE  = 8'h88;
  localparam logic [ByteW-1:0] HDR_PING   = 8'h89;
  localparam logic [ByteW-1:0] HDR_PONG   = 8'h8A;
  localparam logic [6:0]       CODE_LEN16 = 7'd126;
  localparam logic [6:0]       CODE_LEN64 = 7'd127;
  localparam logic [LenW-1:0]  LEN_INLINE_MAX = 63'd125;
  localparam logic [LenW-1:0]  LEN_SHORT_MAX  = 63'd65535;
  localparam logic [IdxW-1:0]  EXT_NONE  = 4'd0;
  localparam logic [IdxW-1:0]  EXT_SHORT = 4'd2;
  localparam logic [IdxW-1:0]  EXT_LONG  = 4'd8;
  localparam logic [IdxW-1:0]  KEY_BYTES = 4'd4;

  typedef enum logic [1:0] {
    JOB_BYTE,    // one ready-made byte (payload or error)
    JOB_HEADER,  // text frame header
    JOB_CTRL     // two-byte control frame
  } job_kind_t;

  // One unit of work for the back end
  typedef struct packed {
    job_kind_t        kind;
    logic [ByteW-1:0] first;      // byte itself, header byte 1, or control byte 0
    logic             last;       // byte job: last flag; header job: length is zero
    logic             err;
    logic [LenW-1:0]  len;
    logic [IdxW-1:0]  ext;        // extended length byte count
    logic [KeyW-1:0]  key;
    logic [IdxW-1:0]  final_idx;  // index of the final byte of this job
  } job_t;

  // Masking key byte, byte 0 in the top bits
  function automatic logic [ByteW-1:0] key_byte(input logic [KeyW-1:0] key,
                                                input logic [1:0] phase);
    logic [ByteW-1:0] b;
    unique case (phase)
      2'd0: b = key[31:24];
      2'd1: b = key[23:16];
      2'd2: b = key[15:8];
      default: b = key[7:0];
    endcase
    return b;
  endfunction

endpackage

/* rtl/wse_front.sv */
`timescale 1ns / 1ps
module wse_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [wse_pkg::CmdW-1:0]  in_command,
  input  logic [wse_pkg::LenW-1:0]  in_payload_length,
  input  logic                      in_mask_present,
  input  logic [wse_pkg::KeyW-1:0]  in_mask_key,
  input  logic [wse_pkg::ByteW-1:0] in_data_byte,
  input  logic                      q_full,
  output logic                      q_push,
  output wse_pkg::job_t             q_job
);
  import wse_pkg::*;

  logic [LenW-1:0] rem_r, rem_nxt;
  logic [1:0]      phase_r, phase_nxt;
  logic [KeyW-1:0] key_r, key_nxt;
  logic            mask_on_r, mask_on_nxt;

  logic accept;
  logic [IdxW-1:0] ext;
  logic [6:0]      len_code;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Length code selection for a start request
  always_comb begin
    priority if (in_payload_length <= LEN_INLINE_MAX) begin
      ext      = EXT_NONE;
      len_code = in_payload_length[6:0];
    end else if (in_payload_length <= LEN_SHORT_MAX) begin
      ext      = EXT_SHORT;
      len_code = CODE_LEN16;
    end else begin
      ext      = EXT_LONG;
      len_code = CODE_LEN64;
    end
  end

  // Classify the request, build the job, update frame state
  always_comb begin
    rem_nxt     = rem_r;
    phase_nxt   = phase_r;
    key_nxt     = key_r;
    mask_on_nxt = mask_on_r;
    q_push      = 1'b0;
    q_job       = '0;
    q_job.len   = in_payload_length;
    q_job.key   = in_mask_key;
    q_job.kind  = JOB_BYTE;
    unique case (in_command)
      CMD_START: begin
        q_push          = accept;
        q_job.kind      = JOB_HEADER;
        q_job.first     = {in_mask_present, len_code};
        q_job.last      = (in_payload_length == '0);
        q_job.ext       = ext;
        q_job.final_idx = 4'd1 + ext + (in_mask_present ? KEY_BYTES : 4'd0);
        rem_nxt         = in_payload_length;
        phase_nxt       = 2'd0;
        key_nxt         = in_mask_present ? in_mask_key : '0;
        mask_on_nxt     = in_mask_present;
      end
      CMD_DATA: begin
        q_push          = accept;
        q_job.final_idx = 4'd0;
        if (rem_r == '0) begin
          q_job.err = 1'b1;
        end else begin
          q_job.first = in_data_byte ^ (mask_on_r ? key_byte(key_r, phase_r) : 8'h00);
          q_job.last  = (rem_r == 63'd1);
          rem_nxt     = rem_r - 63'd1;
          phase_nxt   = phase_r + 2'd1;
        end
      end
      CMD_CLOSE, CMD_PING, CMD_PONG: begin
        q_push          = accept;
        q_job.kind      = JOB_CTRL;
        q_job.final_idx = 4'd1;
        q_job.first     = (in_command == CMD_CLOSE) ? HDR_CLOSE :
                          (in_command == CMD_PING)  ? HDR_PING  : HDR_PONG;
      end
      default: begin
        // undefined command: dropped with no output
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r     <= '0;
      phase_r   <= '0;
      key_r     <= '0;
      mask_on_r <= 1'b0;
    end else if (accept) begin
      rem_r     <= rem_nxt;
      phase_r   <= phase_nxt;
      key_r     <= key_nxt;
      mask_on_r <= mask_on_nxt;
    end
  end

endmodule

/* rtl/wse_queue.sv */
`timescale 1ns / 1ps
module wse_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  wse_pkg::job_t push_job,
  input  logic          pop,
  output wse_pkg::job_t head,
  output logic          empty,
  output logic          full
);
  import wse_pkg::*;

  job_t             mem [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPtrW:0]   count_r;
  logic             do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == (QPtrW+1)'(QDepth));
  assign head    = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* rtl/wse_back.sv */
`timescale 1ns / 1ps
module wse_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  wse_pkg::job_t             q_head,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [wse_pkg::ByteW-1:0] out_byte,
  output logic                      out_last,
  output logic                      out_error
);
  import wse_pkg::*;

  logic [IdxW-1:0]  idx_r;
  logic             out_valid_r;
  logic [ByteW-1:0] out_byte_r;
  logic             out_last_r, out_error_r;

  logic             adv, fire, is_final;
  logic [ByteW-1:0] gen_byte;
  logic             gen_last, gen_err;
  logic [IdxW-1:0]  len_sel, key_sel;
  logic [63:0]      len_word;

  assign adv      = !out_valid_r || out_ready;
  assign fire     = adv && !q_empty;
  assign is_final = (idx_r == q_head.final_idx);
  assign q_pop    = fire && is_final;
  assign len_sel  = q_head.ext + 4'd1 - idx_r;
  assign key_sel  = idx_r - 4'd2 - q_head.ext;
  assign len_word = {1'b0, q_head.len};

  // Byte generator for the job at the queue head
  always_comb begin
    gen_byte = q_head.first;
    gen_last = 1'b0;
    gen_err  = 1'b0;
    unique case (q_head.kind)
      JOB_BYTE: begin
        gen_last = q_head.last;
        gen_err  = q_head.err;
      end
      JOB_HEADER: begin
        gen_last = is_final && q_head.last;
        priority if (idx_r == 4'd0) begin
          gen_byte = HDR_TEXT;
        end else if (idx_r == 4'd1) begin
          gen_byte = q_head.first;
        end else if (idx_r < 4'd2 + q_head.ext) begin
          gen_byte = len_word[{len_sel[2:0], 3'b000} +: 8];
        end else begin
          gen_byte = key_byte(q_head.key, key_sel[1:0]);
        end
      end
      JOB_CTRL: begin
        gen_last = is_final;
        gen_byte = is_final ? 8'h00 : q_head.first;
      end
      default: begin
        gen_byte = 8'h00;
      end
    endcase
  end

  // Output register and byte index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (adv) out_valid_r <= !q_empty;
      if (fire) idx_r <= is_final ? '0 : idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte_r  <= gen_byte;
      out_last_r  <= gen_last;
      out_error_r <= gen_err;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;
  assign out_error = out_error_r;

endmodule

/* rtl/websocket_frame_encoder.sv */
// A request's first byte goes through the job queue and then the output register.
// Throughput: one output byte per cycle while out_ready is high; a payload byte or error
//   gives 1 byte, a start 2 to 14 bytes (header length), a close/ping/pong 2 bytes.
// A 4-entry job queue sits between front and back; in_ready drops only when it is full.
// Reset (rst_n low, synchronous) clears frame state, the queue and the output valid flag.
`timescale 1ns / 1ps
module websocket_frame_encoder (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [wse_pkg::CmdW-1:0]  in_command,
  input  logic [wse_pkg::LenW-1:0]  in_payload_length,
  input  logic                      in_mask_present,
  input  logic [wse_pkg::KeyW-1:0]  in_mask_key,
  input  logic [wse_pkg::ByteW-1:0] in_data_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [wse_pkg::ByteW-1:0] out_byte,
  output logic                      out_last,
  output logic                      out_error
);
  import wse_pkg::*;

  job_t push_job, head_job;
  logic push, pop, q_empty, q_full;

  wse_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_payload_length (in_payload_length),
    .in_mask_present   (in_mask_present),
    .in_mask_key       (in_mask_key),
    .in_data_byte      (in_data_byte),
    .q_full            (q_full),
    .q_push            (push),
    .q_job             (push_job)
  );

  wse_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  wse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (head_job),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_error (out_error)
  );

endmodule

/* rtl/wse_checker.sv */
`timescale 1ns / 1ps
module wse_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       out_error
);

  // A stalled result holds its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last)
      && $stable(out_error))
    else $error("output changed while stalled");

  // Error result carries a zero byte and never closes a frame
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_byte == 8'h00 && !out_last)
    else $error("malformed error result");

  // Reset empties the output stage
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Reset empties the job queue, so requests are taken again
  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("not ready after reset");

endmodule

bind websocket_frame_encoder wse_checker u_wse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte),
  .out_last  (out_last),
  .out_error (out_error)
);
